FILE: src/itr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package itr_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int MAX_DIGITS_DEF = 64;
	localparam int STEP_BITS      = 8;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [5:0] MIN_RADIX = 6'd2;
	localparam logic [5:0] MAX_RADIX = 6'd36;

	localparam logic [6:0] CHAR_ZERO     = 7'd48;
	localparam logic [6:0] CHAR_ALPHA    = 7'd87;
	localparam logic [6:0] CHAR_BAD      = 7'd63;
	localparam logic [5:0] DECIMAL_LIMIT = 6'd10;

	typedef struct packed {
		logic [63:0] value;
		logic [5:0]  base;
	} itr_in_t;

	typedef struct packed {
		logic [6:0] digit_char;
		logic       last;
	} itr_out_t;

	typedef struct packed {
		logic [63:0] value;
		logic [5:0]  radix;
	} itr_job_t;

	// "0123456789abcdefghijklmnopqrstuvwxyz", '?' past the end
	function automatic logic [6:0] digit_ascii(input logic [5:0] d);
		logic [6:0] c;
		if (d < DECIMAL_LIMIT) begin
			c = CHAR_ZERO + {1'b0, d};
		end else if (d <= (MAX_RADIX - 6'd1)) begin
			c = CHAR_ALPHA + {1'b0, d};
		end else begin
			c = CHAR_BAD;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: src/itr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module itr_front #(
	parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  itr_pkg::itr_in_t      req,
	input  wire logic             q_full,
	output logic                  q_push,
	output itr_pkg::itr_job_t     q_job
);

	assign req_stall = q_full;
	assign q_push    = req_valid & ~q_full;

	// drop value bits above VALUE_BITS, clamp radix into 2..36
	always_comb begin
		q_job.value = 64'(req.value[VALUE_BITS-1:0]);
		if (req.base < itr_pkg::MIN_RADIX) begin
			q_job.radix = itr_pkg::MIN_RADIX;
		end else if (req.base > itr_pkg::MAX_RADIX) begin
			q_job.radix = itr_pkg::MAX_RADIX;
		end else begin
			q_job.radix = req.base;
		end
	end

endmodule
`default_nettype wire

FILE: src/itr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module itr_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  itr_pkg::itr_job_t push_job,
	output logic              full,
	input  wire logic         pop,
	output logic              nonempty,
	output itr_pkg::itr_job_t head
);

	localparam int QW = (itr_pkg::QUEUE_DEPTH > 1) ? $clog2(itr_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(itr_pkg::QUEUE_DEPTH + 1);

	itr_pkg::itr_job_t slot_q [itr_pkg::QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(itr_pkg::QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QW'(itr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QW'(itr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

FILE: src/itr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module itr_back #(
	parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF,
	parameter int MAX_DIGITS = itr_pkg::MAX_DIGITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_nonempty,
	input  itr_pkg::itr_job_t q_head,
	output logic              q_pop,
	output logic              rsp_valid,
	input  wire logic         rsp_stall,
	output itr_pkg::itr_out_t rsp
);

	localparam int SB     = itr_pkg::STEP_BITS;
	localparam int CHUNKS = (VALUE_BITS + SB - 1) / SB;
	localparam int DIV_W  = CHUNKS * SB;
	localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int AW     = $clog2(MAX_DIGITS);
	localparam int NW     = $clog2(MAX_DIGITS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [DIV_W-1:0] dvd_q;
	logic [5:0]       radix_q;
	logic [5:0]       rem_q;
	logic [CW-1:0]    chunk_q;
	logic [NW-1:0]    cnt_q;
	logic [NW-1:0]    issue_q;
	logic             rd_valid_q;
	logic             rd_last_q;
	logic [5:0]       rd_data_q;
	logic             out_valid_q;
	itr_pkg::itr_out_t out_q;
	logic [5:0]       digit_mem [MAX_DIGITS];

	logic [6:0]       r;
	logic [SB-1:0]    qbits;
	logic [5:0]       rem_nx;
	logic [DIV_W-1:0] dvd_nx;
	logic             digit_done;
	logic             run_done;
	logic             move;
	logic             issue;
	logic [NW-1:0]    rd_idx;

	// one dividend byte per cycle: eight restoring steps on a narrow remainder
	always_comb begin
		r = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < SB; i++) begin
			r = {r[5:0], dvd_q[DIV_W-1-i]};
			qbits[SB-1-i] = (r >= {1'b0, radix_q});
			if (qbits[SB-1-i]) begin
				r = r - {1'b0, radix_q};
			end
		end
		rem_nx = r[5:0];
		dvd_nx = (dvd_q << SB) | DIV_W'(qbits);
	end

	assign digit_done = (state_q == ST_DIV) && (chunk_q == CW'(CHUNKS - 1));
	assign run_done   = (dvd_nx == '0) || ((cnt_q + 1'b1) == NW'(MAX_DIGITS));
	assign q_pop      = (state_q == ST_IDLE) && q_nonempty;

	assign move   = rd_valid_q && (!out_valid_q || !rsp_stall);
	assign issue  = (state_q == ST_EMIT) && (issue_q != cnt_q) && (!rd_valid_q || move);
	assign rd_idx = cnt_q - issue_q - NW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chunk_q     <= '0;
			cnt_q       <= '0;
			issue_q     <= '0;
			rd_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_nonempty) begin
						chunk_q <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (digit_done) begin
						chunk_q <= '0;
						cnt_q   <= cnt_q + 1'b1;
						if (run_done) begin
							issue_q <= '0;
							state_q <= ST_EMIT;
						end
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (issue_q == cnt_q && !rd_valid_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (issue) begin
				issue_q <= issue_q + 1'b1;
			end
			if (issue) begin
				rd_valid_q <= 1'b1;
			end else if (move) begin
				rd_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			dvd_q   <= q_head.value[DIV_W-1:0];
			radix_q <= q_head.radix;
			rem_q   <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= dvd_nx;
			rem_q <= digit_done ? 6'd0 : rem_nx;
		end
		if (move) begin
			out_q.digit_char <= itr_pkg::digit_ascii(rd_data_q);
			out_q.last       <= rd_last_q;
		end
	end

	// digit store: written least significant first, read back in reverse
	always_ff @(posedge clk) begin
		if (digit_done) begin
			digit_mem[cnt_q[AW-1:0]] <= rem_nx;
		end
		if (issue) begin
			rd_data_q <= digit_mem[rd_idx[AW-1:0]];
			rd_last_q <= ((issue_q + 1'b1) == cnt_q);
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

FILE: src/integer_to_radix_digits.sv
`timescale 1ns / 1ps
`default_nettype none
// Converts an unsigned integer into radix 2..36 ASCII digits, most significant first.
// Each digit is found by dividing by the radix, one dividend byte per cycle in the
// divide unit; the digits are then streamed back out of the digit store.
// A two-entry queue accepts new items while a run is in progress.
// Reset clears all control state; the digit store is always written before it is read.
module integer_to_radix_digits #(
	parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF,
	parameter int MAX_DIGITS = itr_pkg::MAX_DIGITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_stall,
	input  itr_pkg::itr_in_t  req,
	output logic              rsp_valid,
	input  wire logic         rsp_stall,
	output itr_pkg::itr_out_t rsp
);

	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              q_nonempty;
	itr_pkg::itr_job_t q_job;
	itr_pkg::itr_job_t q_head;

	itr_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_job)
	);

	itr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(q_job),
		.full    (q_full),
		.pop     (q_pop),
		.nonempty(q_nonempty),
		.head    (q_head)
	);

	itr_back #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_DIGITS(MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_nonempty(q_nonempty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
